// ----- design/brange_pkg.sv -----
// brange_pkg: shared constants, op codes, command struct and word helpers
// for the bitmap range engine. No dependencies.
`default_nettype none
package brange_pkg;

   localparam int NUM_WORDS = 16;
   localparam int WORD_BITS = 64;
   localparam int IDX_W     = $clog2(NUM_WORDS);
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int POS_W     = 11;
   localparam int OP_W      = 4;
   localparam int FROM_W    = 10;
   localparam int CNT_W     = BIT_W + 1;

   localparam logic [POS_W-1:0] CAP_BITS = POS_W'(NUM_WORDS * WORD_BITS);
   localparam logic [IDX_W-1:0] LAST_WORD = IDX_W'(NUM_WORDS - 1);

   localparam logic [OP_W-1:0] OP_TEST       = 4'd0;
   localparam logic [OP_W-1:0] OP_SET_RANGE  = 4'd1;
   localparam logic [OP_W-1:0] OP_CLR_RANGE  = 4'd2;
   localparam logic [OP_W-1:0] OP_FLIP_RANGE = 4'd3;
   localparam logic [OP_W-1:0] OP_NEXT_SET   = 4'd4;
   localparam logic [OP_W-1:0] OP_NEXT_CLR   = 4'd5;
   localparam logic [OP_W-1:0] OP_PREV_SET   = 4'd6;
   localparam logic [OP_W-1:0] OP_PREV_CLR   = 4'd7;
   localparam logic [OP_W-1:0] OP_CLEAR_ALL  = 4'd8;
   localparam logic [OP_W-1:0] OP_COUNT      = 4'd9;

   typedef struct packed {
      logic             load;      // latch request, reset accumulators
      logic             step;      // process one word
      logic             capture;   // move result into output register
      logic [IDX_W-1:0] word_idx;
   } cmd_type;

   function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

   function automatic logic [BIT_W-1:0] highest_set(input logic [WORD_BITS-1:0] v);
      logic [BIT_W-1:0] r;
      r = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) r = BIT_W'(i);
      end
      return r;
   endfunction

   function automatic logic [CNT_W-1:0] popcount(input logic [WORD_BITS-1:0] v);
      logic [CNT_W-1:0] c;
      c = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         c = c + CNT_W'(v[i]);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ----- design/brange_ctrl.sv -----
// brange_ctrl: sequencer for the bitmap range engine; walks the word index
// and owns both handshakes. Depends on brange_pkg.
`default_nettype none
module brange_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output brange_pkg::cmd_type     cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]                  state_ff, state_in;
   logic [brange_pkg::IDX_W-1:0] idx_ff, idx_in;
   logic                        valid_ff, valid_in;
   logic                        out_free;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;
   assign out_free  = !valid_ff || !rsp_stall;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd.load     = 1'b0;
      cmd.step     = 1'b0;
      cmd.capture  = 1'b0;
      cmd.word_idx = idx_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               idx_in   = '0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.step = 1'b1;
            idx_in   = idx_ff + 1'b1;
            if (idx_ff == brange_pkg::LAST_WORD) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.capture = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.capture) valid_in = 1'b1;
      else if (valid_ff && !rsp_stall) valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

endmodule
`default_nettype wire

// ----- design/brange_dp.sv -----
// brange_dp: word store, per-word modify/search/count unit, accumulators and
// result register of the bitmap range engine. Depends on brange_pkg.
`default_nettype none
module brange_dp (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire brange_pkg::cmd_type               cmd,
   input  wire logic [brange_pkg::OP_W-1:0]       req_op,
   input  wire logic [brange_pkg::FROM_W-1:0]     req_from_index,
   input  wire logic [brange_pkg::POS_W-1:0]      req_to_index,
   output logic                                   rsp_bit_value,
   output logic                                   rsp_found,
   output logic [brange_pkg::POS_W-1:0]           rsp_position,
   output logic [brange_pkg::POS_W-1:0]           rsp_count,
   output logic [brange_pkg::POS_W-1:0]           rsp_bit_length,
   output logic                                   rsp_empty_res,
   output logic                                   rsp_error
);

   localparam int W = brange_pkg::WORD_BITS;
   localparam int B = brange_pkg::BIT_W;
   localparam int P = brange_pkg::POS_W;

   logic [W-1:0] words_ff [brange_pkg::NUM_WORDS];

   // request copy
   logic [brange_pkg::OP_W-1:0]   op_ff;
   logic [brange_pkg::FROM_W-1:0] from_ff;
   logic [P-1:0]                  to_ff;
   logic                          err_ff, err_in;

   // accumulators
   logic         bitv_ff, found_ff;
   logic [P-1:0] pos_ff, cnt_ff, blen_ff;

   // result register
   logic         o_bitv_ff, o_found_ff, o_err_ff;
   logic [P-1:0] o_pos_ff, o_cnt_ff, o_blen_ff;

   logic [brange_pkg::IDX_W-1:0] idx;
   logic [W-1:0] word_q, word_new, ge_mask, le_mask, lt_mask, rmask, tgt;
   logic [W-1:0] cand_next, cand_prev;
   logic [P-1:0] to_c;
   logic [brange_pkg::IDX_W:0] to_word;
   logic [brange_pkg::IDX_W-1:0] from_word;
   logic         is_range, do_mod, is_next, is_prev;

   assign idx       = cmd.word_idx;
   assign word_q    = words_ff[idx];
   assign from_word = from_ff[brange_pkg::FROM_W-1:B];
   assign to_c      = (to_ff > brange_pkg::CAP_BITS) ? brange_pkg::CAP_BITS : to_ff;
   assign to_word   = to_c[P-1:B];
   assign is_range  = (op_ff == brange_pkg::OP_SET_RANGE) || (op_ff == brange_pkg::OP_CLR_RANGE)
                   || (op_ff == brange_pkg::OP_FLIP_RANGE);
   assign do_mod    = is_range && !err_ff;
   assign is_next   = (op_ff == brange_pkg::OP_NEXT_SET) || (op_ff == brange_pkg::OP_NEXT_CLR);
   assign is_prev   = (op_ff == brange_pkg::OP_PREV_SET) || (op_ff == brange_pkg::OP_PREV_CLR);

   // per-word masks against the request indexes
   always_comb begin
      if (idx > from_word)       ge_mask = '1;
      else if (idx == from_word) ge_mask = '1 << from_ff[B-1:0];
      else                       ge_mask = '0;
      if (idx < from_word)       le_mask = '1;
      else if (idx == from_word) le_mask = '1 >> (B'(W - 1) - from_ff[B-1:0]);
      else                       le_mask = '0;
      if ({1'b0, idx} < to_word)       lt_mask = '1;
      else if ({1'b0, idx} == to_word) lt_mask = ~('1 << to_c[B-1:0]);
      else                             lt_mask = '0;
      rmask = ge_mask & lt_mask;
   end

   always_comb begin
      word_new = word_q;
      case (op_ff)
         brange_pkg::OP_SET_RANGE:  if (do_mod) word_new = word_q | rmask;
         brange_pkg::OP_CLR_RANGE:  if (do_mod) word_new = word_q & ~rmask;
         brange_pkg::OP_FLIP_RANGE: if (do_mod) word_new = word_q ^ rmask;
         brange_pkg::OP_CLEAR_ALL:  word_new = '0;
         default:                   word_new = word_q;
      endcase
   end

   assign tgt = ((op_ff == brange_pkg::OP_NEXT_SET) || (op_ff == brange_pkg::OP_PREV_SET))
              ? word_q : ~word_q;
   assign cand_next = tgt & ge_mask;
   assign cand_prev = tgt & le_mask;

   assign err_in = ((req_op == brange_pkg::OP_SET_RANGE) || (req_op == brange_pkg::OP_CLR_RANGE)
                 || (req_op == brange_pkg::OP_FLIP_RANGE)) && (req_to_index < P'(req_from_index));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < brange_pkg::NUM_WORDS; i++) words_ff[i] <= '0;
      end else if (cmd.step) begin
         words_ff[idx] <= word_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_op;
         from_ff  <= req_from_index;
         to_ff    <= req_to_index;
         err_ff   <= err_in;
         bitv_ff  <= 1'b0;
         found_ff <= 1'b0;
         pos_ff   <= '0;
         cnt_ff   <= '0;
         blen_ff  <= '0;
      end else if (cmd.step) begin
         if ((op_ff == brange_pkg::OP_TEST) && (idx == from_word))
            bitv_ff <= word_q[from_ff[B-1:0]];
         if (is_next && !found_ff && (cand_next != '0)) begin
            found_ff <= 1'b1;
            pos_ff   <= P'({idx, brange_pkg::lowest_set(cand_next)});
         end
         if (is_prev && (cand_prev != '0)) begin
            found_ff <= 1'b1;
            pos_ff   <= P'({idx, brange_pkg::highest_set(cand_prev)});
         end
         cnt_ff <= cnt_ff + P'(brange_pkg::popcount(word_new));
         if (word_new != '0)
            blen_ff <= P'({idx, brange_pkg::highest_set(word_new)}) + P'(1);
      end
   end

   // result register; next-clear always succeeds, at capacity if need be
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         o_bitv_ff <= (op_ff == brange_pkg::OP_TEST) ? bitv_ff : 1'b0;
         o_err_ff  <= err_ff;
         o_cnt_ff  <= (op_ff == brange_pkg::OP_COUNT) ? cnt_ff : '0;
         o_blen_ff <= blen_ff;
         if ((op_ff == brange_pkg::OP_NEXT_CLR) && !found_ff) begin
            o_found_ff <= 1'b1;
            o_pos_ff   <= brange_pkg::CAP_BITS;
         end else begin
            o_found_ff <= found_ff;
            o_pos_ff   <= pos_ff;
         end
      end
   end

   assign rsp_bit_value  = o_bitv_ff;
   assign rsp_found      = o_found_ff;
   assign rsp_position   = o_pos_ff;
   assign rsp_count      = o_cnt_ff;
   assign rsp_bit_length = o_blen_ff;
   assign rsp_empty_res  = (o_blen_ff == '0);
   assign rsp_error      = o_err_ff;

endmodule
`default_nettype wire

// ----- design/bitmap_range_engine.sv -----
// From the accepting edge the sequencer steps through the 16 words, then it
// captures, raising rsp_valid and returning to idle in that same cycle. No new
// transaction is taken before then, as the single word-wide modify/search/count
// unit serves every step. A stalled result holds the next one in capture.
// The result register holds a finished transaction while the next is taken.
// Reset (synchronous, active high) clears all 1024 map bits and the control.
// bitmap_range_engine: top level; depends on brange_pkg, brange_ctrl, brange_dp.
`default_nettype none
module bitmap_range_engine (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire logic [3:0]   req_op,
   input  wire logic [9:0]   req_from_index,
   input  wire logic [10:0]  req_to_index,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output logic              rsp_bit_value,
   output logic              rsp_found,
   output logic [10:0]       rsp_position,
   output logic [10:0]       rsp_count,
   output logic [10:0]       rsp_bit_length,
   output logic              rsp_empty_res,
   output logic              rsp_error
);

   // command bundle from sequencer to datapath
   brange_pkg::cmd_type cmd;

   // sequencer: accepts one transaction, sweeps words 0..15, then captures
   brange_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // datapath: each word step modifies, searches, counts and tracks length
   brange_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .req_op         (req_op),
      .req_from_index (req_from_index),
      .req_to_index   (req_to_index),
      .rsp_bit_value  (rsp_bit_value),
      .rsp_found      (rsp_found),
      .rsp_position   (rsp_position),
      .rsp_count      (rsp_count),
      .rsp_bit_length (rsp_bit_length),
      .rsp_empty_res  (rsp_empty_res),
      .rsp_error      (rsp_error)
   );

endmodule
`default_nettype wire

// ----- design/brange_checker.sv -----
// brange_checker: port-level checks for bitmap_range_engine, bound to it.
// Depends only on the top-level ports.
`default_nettype none
module brange_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic        rsp_found,
   input wire logic [10:0] rsp_count,
   input wire logic [10:0] rsp_bit_length,
   input wire logic        rsp_empty_res,
   input wire logic        rsp_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid) else $error("result dropped while stalled");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall) else $error("not busy after accept");

   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_empty_res == (rsp_bit_length == 11'd0))
      else $error("empty flag disagrees with bit length");

   a_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |-> !rsp_found && (rsp_count == 11'd0))
      else $error("error transaction reports a search or count");

endmodule

bind bitmap_range_engine brange_checker u_brange_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_found      (rsp_found),
   .rsp_count      (rsp_count),
   .rsp_bit_length (rsp_bit_length),
   .rsp_empty_res  (rsp_empty_res),
   .rsp_error      (rsp_error)
);
`default_nettype wire

// ----- dv/bitmap_range_checker.sv -----
// bitmap_range_checker: watches both channels of the bitmap range engine, keeps its own
// copy of the 1024-bit map, predicts each result and compares. Depends on brange_pkg.
module bitmap_range_checker (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [3:0]  req_op,
   input  wire logic [9:0]  req_from_index,
   input  wire logic [10:0] req_to_index,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_bit_value,
   input  wire logic        rsp_found,
   input  wire logic [10:0] rsp_position,
   input  wire logic [10:0] rsp_count,
   input  wire logic [10:0] rsp_bit_length,
   input  wire logic        rsp_empty_res,
   input  wire logic        rsp_error,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);

   typedef struct packed {
      logic        bit_value;
      logic        found;
      logic [10:0] position;
      logic [10:0] count;
      logic [10:0] bit_length;
      logic        empty_res;
      logic        error;
   } answer_type;

   logic [1023:0] map_bits;
   answer_type    answer_q[$];

   task automatic report(input string what, input int got, input int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      fail_count++;
   endtask

   // bit length = highest set index + 1; words above the last nonzero are all zero
   function automatic int top_len();
      int i;
      for (i = 1023; i >= 0; i--)
         if (map_bits[i]) return i + 1;
      return 0;
   endfunction

   function automatic answer_type apply_op(input logic [3:0] op, input int from, input int to);
      answer_type a;
      int         used_lim, i;
      a = '0;
      used_lim = ((top_len() + 63) / 64) * 64;
      case (op)
         brange_pkg::OP_TEST: a.bit_value = map_bits[from];
         brange_pkg::OP_SET_RANGE, brange_pkg::OP_CLR_RANGE, brange_pkg::OP_FLIP_RANGE: begin
            if (to < from) a.error = 1'b1;
            else begin
               if (to > 1024) to = 1024;
               for (i = from; i < to; i++)
                  map_bits[i] = (op == brange_pkg::OP_SET_RANGE) ? 1'b1 :
                                (op == brange_pkg::OP_CLR_RANGE) ? 1'b0 : !map_bits[i];
            end
         end
         brange_pkg::OP_NEXT_SET:
            for (i = from; i < used_lim; i++)
               if (map_bits[i]) begin
                  a.found = 1'b1; a.position = 11'(i); break;
               end
         brange_pkg::OP_NEXT_CLR: begin
            i = from;
            while (i < used_lim && map_bits[i]) i++;
            a.found = 1'b1;
            a.position = 11'(i);
         end
         brange_pkg::OP_PREV_SET, brange_pkg::OP_PREV_CLR:
            for (i = from; i >= 0; i--)
               if (map_bits[i] == (op == brange_pkg::OP_PREV_SET)) begin
                  a.found = 1'b1; a.position = 11'(i); break;
               end
         brange_pkg::OP_CLEAR_ALL: map_bits = '0;
         brange_pkg::OP_COUNT: a.count = 11'($countones(map_bits));
         default: ;
      endcase
      a.bit_length = 11'(top_len());
      a.empty_res = (map_bits == '0);
      return a;
   endfunction

   always @(posedge clock) begin
      answer_type got, want;
      if (reset) begin
         map_bits = '0;
         answer_q.delete();
         fail_count <= 0;
         rsp_seen <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            rsp_seen <= rsp_seen + 1;
            got = {rsp_bit_value, rsp_found, rsp_position, rsp_count,
                   rsp_bit_length, rsp_empty_res, rsp_error};
            if (answer_q.size() == 0) report("unexpected transaction", 1, 0);
            else begin
               want = answer_q.pop_front();
               if (got.bit_value != want.bit_value)
                  report("bit_value", got.bit_value, want.bit_value);
               if (got.found != want.found) report("found", got.found, want.found);
               if (got.position != want.position)
                  report("position", got.position, want.position);
               if (got.count != want.count) report("count", got.count, want.count);
               if (got.bit_length != want.bit_length)
                  report("bit_length", got.bit_length, want.bit_length);
               if (got.empty_res != want.empty_res)
                  report("empty_res", got.empty_res, want.empty_res);
               if (got.error != want.error) report("error", got.error, want.error);
            end
         end
         // blocking update of the map is fine: only this process touches it
         if (req_valid && !req_stall)
            answer_q.push_back(apply_op(req_op, int'(req_from_index), int'(req_to_index)));
         pending_count <= answer_q.size();
      end
   end

endmodule

// ----- dv/bitmap_range_engine_tb.sv -----
// bitmap_range_engine_tb: stimulus and verdict for the bitmap range engine.
// Depends on brange_pkg, bitmap_range_engine and bitmap_range_checker.
module bitmap_range_engine_tb;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [3:0]  req_op = '0;
   logic [9:0]  req_from_index = '0;
   logic [10:0] req_to_index = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_bit_value, rsp_found, rsp_empty_res, rsp_error;
   logic [10:0] rsp_position, rsp_count, rsp_bit_length;

   int fail_count, pending_count, rsp_seen;
   int cycle_count = 0;
   int sender_idle_pct = 0;   // chance in 100 of an idle cycle before a transaction
   int stall_pct = 0;         // chance in 100 the receiver stalls in a cycle
   bit long_hold = 1'b0;      // forces a long receiver hold-off
   int sent = 0;

   localparam int CYCLE_LIMIT = 600000;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bitmap_range_engine u_top (.*);

   bitmap_range_checker u_chk (.*);

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // receiver stall, decided at the falling edge
   always @(negedge clock) begin
      rsp_stall <= long_hold || ($urandom_range(99) < stall_pct);
   end

   // runaway guard
   always @(posedge clock) begin
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("bitmap_range_engine_tb NOT OK");
         $finish;
      end
   end

   // one transaction; valid held through stalls, payload steady; valid is
   // left high on return so the next call can replace the payload directly
   task automatic send(input logic [3:0] op, input int from, input int to);
      logic stalled;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_from_index <= 10'(from);
      req_to_index   <= 11'(to);
      // req_stall only moves at a rising edge, so read it between edges
      forever begin
         stalled = req_stall;
         @(posedge clock);
         if (!stalled) break;
         @(negedge clock);
      end
      @(negedge clock);
      sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   // mostly ranges and searches near word edges, small ranges, some wide ones
   task automatic random_item();
      int op_pick, from, to;
      op_pick = $urandom_range(99);
      from = ($urandom_range(3) == 0) ? $urandom_range(1023)
           : ($urandom_range(15) * 64 + $urandom_range(2) * 63 + $urandom_range(1)) % 1024;
      case ($urandom_range(5))
         0: to = $urandom_range(1024, 2047);          // past capacity, clamped
         1: to = $urandom_range(2047);
         2: to = (from > 3) ? from - $urandom_range(1, 3) : from;  // reversed
         default: to = from + $urandom_range(150);
      endcase
      if (to > 2047) to = 2047;
      if (op_pick < 36) send(brange_pkg::OP_SET_RANGE + 4'($urandom_range(2)), from, to);
      else if (op_pick < 86)
         send(brange_pkg::OP_TEST + 4'($urandom_range(7) == 0 ? 0 : $urandom_range(4, 7)),
              from, to);
      else if (op_pick < 94) send(brange_pkg::OP_COUNT, from, to);
      else if (op_pick < 96) send(brange_pkg::OP_CLEAR_ALL, from, to);
      else send(4'($urandom_range(10, 15)), from, to);
   endtask

   initial begin
      int idle_set[4] = '{0, 75, 0, 75};
      int stall_set[4] = '{0, 0, 75, 75};
      int hold;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty-map searches, full-width ranges, reversed and empty ranges
      send(brange_pkg::OP_NEXT_SET, 0, 0);
      send(brange_pkg::OP_NEXT_CLR, 1023, 0);
      send(brange_pkg::OP_PREV_SET, 1023, 0);
      send(brange_pkg::OP_PREV_CLR, 0, 0);
      send(brange_pkg::OP_SET_RANGE, 0, 2047);
      send(brange_pkg::OP_COUNT, 0, 0);
      send(brange_pkg::OP_NEXT_CLR, 5, 0);
      send(brange_pkg::OP_PREV_CLR, 1023, 0);
      send(brange_pkg::OP_TEST, 1023, 0);
      send(brange_pkg::OP_CLR_RANGE, 10, 9);
      send(brange_pkg::OP_CLR_RANGE, 500, 500);
      send(brange_pkg::OP_FLIP_RANGE, 63, 65);
      send(brange_pkg::OP_PREV_CLR, 1023, 0);
      send(brange_pkg::OP_NEXT_CLR, 0, 0);
      send(brange_pkg::OP_CLR_RANGE, 1, 1024);
      send(brange_pkg::OP_TEST, 0, 1024);
      send(brange_pkg::OP_NEXT_CLR, 0, 0);
      send(brange_pkg::OP_NEXT_SET, 1, 0);
      send(brange_pkg::OP_PREV_SET, 1023, 0);
      send(4'd15, 682, 1365);
      send(brange_pkg::OP_FLIP_RANGE, 341, 1365);
      send(brange_pkg::OP_CLEAR_ALL, 0, 0);
      send(brange_pkg::OP_TEST, 0, 0);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         sender_idle_pct = (ph == 4) ? 17 : idle_set[ph % 4];
         stall_pct       = (ph == 4) ? 17 : stall_set[ph % 4];
         for (int k = 0; k < 225; k++) random_item();
         // sender pause until the engine has drained
         drain();
      end

      // long receiver hold-off while the sender keeps offering
      sender_idle_pct = 0;
      stall_pct = 0;
      fork
         begin
            long_hold = 1'b1;
            hold = 0;
            while (hold < 200) begin
               @(posedge clock);
               hold++;
            end
            long_hold = 1'b0;
         end
         for (int k = 0; k < 20; k++) random_item();
      join
      drain();
      repeat (40) @(negedge clock);

      $display("sent %0d transactions, %0d results checked, across five idle/stall mixes",
               sent, rsp_seen);
      $display("plus a long receiver hold-off with the sender busy");
      if (fail_count == 0 && pending_count == 0) begin
         $display("bitmap_range_engine_tb OK");
      end else begin
         $display("bitmap_range_engine_tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/brange_pkg.sv
design/brange_ctrl.sv
design/brange_dp.sv
design/bitmap_range_engine.sv
design/brange_checker.sv
dv/bitmap_range_checker.sv
dv/bitmap_range_engine_tb.sv
